// ===== rtl/lsc_pkg.sv =====
// Shared types, constants and the region outcode function for the line
// segment clipper. No dependencies.
package lsc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CW_MAX         = 16;
  localparam int unsigned MAX_PASSES     = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef logic [3:0] outcode_t;
  typedef logic signed [CW_MAX:0] wide_t;

  localparam outcode_t CODE_LEFT   = 4'd1;
  localparam outcode_t CODE_RIGHT  = 4'd2;
  localparam outcode_t CODE_BOTTOM = 4'd4;
  localparam outcode_t CODE_TOP    = 4'd8;

  localparam logic CFG_WINDOW_RIGHT  = 1'b0;
  localparam logic CFG_WINDOW_BOTTOM = 1'b1;

  // Outcode of a point against the window [0, right] x [0, bottom]
  function automatic outcode_t region(input wide_t x, input wide_t y,
                                      input wide_t right, input wide_t bottom);
    outcode_t c;
    c = '0;
    if (x < 0) c = c | CODE_LEFT;
    else if (x > right) c = c | CODE_RIGHT;
    if (y < 0) c = c | CODE_BOTTOM;
    else if (y > bottom) c = c | CODE_TOP;
    return c;
  endfunction

endpackage

// ===== rtl/lsc_front.sv =====
// Front end of the clipper: accepts segments and tags each endpoint with its
// outcode before queueing. Depends on lsc_pkg.
module lsc_front #(
  parameter int unsigned COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  logic        [COORD_BITS-2:0]  win_right_i,
  input  logic        [COORD_BITS-2:0]  win_bottom_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic        [4*COORD_BITS+7:0] q_word_o
);
  import lsc_pkg::*;

  outcode_t code_a, code_b;

  // Classify both endpoints
  always_comb begin
    code_a = region(wide_t'(start_x_i), wide_t'(start_y_i),
                    wide_t'(win_right_i), wide_t'(win_bottom_i));
    code_b = region(wide_t'(end_x_i), wide_t'(end_y_i),
                    wide_t'(win_right_i), wide_t'(win_bottom_i));
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i & ~q_full_i;
  assign q_word_o = {start_x_i, start_y_i, end_x_i, end_y_i, code_a, code_b};

endmodule

// ===== rtl/lsc_queue.sv =====
// Small register queue between the front and back ends of the clipper.
// Depends on nothing.
module lsc_queue #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] word_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] word_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign word_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= word_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== rtl/lsc_back.sv =====
// Back end of the clipper: iterative Cohen-Sutherland passes with a
// bit-serial divider, plus the result register. Depends on lsc_pkg.
module lsc_back #(
  parameter int unsigned COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic        [COORD_BITS-2:0]  win_right_i,
  input  logic        [COORD_BITS-2:0]  win_bottom_i,
  input  logic                          q_valid_i,
  input  logic        [4*COORD_BITS+7:0] q_word_i,
  output logic                          q_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic                          visible_o,
  output logic signed [COORD_BITS-1:0]  clipped_start_x_o,
  output logic signed [COORD_BITS-1:0]  clipped_start_y_o,
  output logic signed [COORD_BITS-1:0]  clipped_end_x_o,
  output logic signed [COORD_BITS-1:0]  clipped_end_y_o
);
  import lsc_pkg::*;

  localparam int unsigned W   = COORD_BITS;
  localparam int unsigned NB  = 2 * W + 2;
  localparam int unsigned CNW = $clog2(NB + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [W-1:0] ax_q, ay_q, bx_q, by_q, ax_d, ay_d, bx_d, by_d;
  outcode_t            ca_q, cb_q, ca_d, cb_d;
  logic [2:0]          pass_q, pass_d;
  logic                acc_q, acc_d;
  logic                move_a_q, move_a_d;
  logic                ybound_q, ybound_d;
  logic signed [W-1:0] base_q, base_d, tgt_q, tgt_d;
  logic [W:0]          dlt_mag_q, dlt_mag_d, dist_mag_q, dist_mag_d, den_mag_q, den_mag_d;
  logic                neg_q, neg_d;
  logic [NB-1:0]       num_q, num_d;
  logic [W+1:0]        rem_q, rem_d;
  logic [CNW-1:0]      cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic                vis_q;
  logic signed [W-1:0] osx_q, osy_q, oex_q, oey_q;
  logic                out_load;

  // Combinational helpers for the boundary choice, the division step and the new coordinate
  outcode_t            co;
  logic                ybnd;
  logic signed [W-1:0] ty, tx;
  logic signed [W:0]   dlt, ofs, den;
  logic [W+1:0]        rem_sh;
  logic signed [W:0]   qs;
  logic signed [W:0]   newc_w;
  logic signed [W-1:0] newc, nx, ny;

  function automatic logic [W:0] mag(input logic signed [W:0] v);
    return v[W] ? (W+1)'(-v) : (W+1)'(v);
  endfunction

  always_comb begin
    co   = (ca_q != '0) ? ca_q : cb_q;
    ybnd = ((co & (CODE_TOP | CODE_BOTTOM)) != '0);
    ty   = ((co & CODE_TOP) != '0) ? $signed({1'b0, win_bottom_i}) : '0;
    tx   = ((co & CODE_RIGHT) != '0) ? $signed({1'b0, win_right_i}) : '0;
    if (ybnd) begin
      dlt = {bx_q[W-1], bx_q} - {ax_q[W-1], ax_q};
      ofs = {ty[W-1], ty} - {ay_q[W-1], ay_q};
      den = {by_q[W-1], by_q} - {ay_q[W-1], ay_q};
    end else begin
      dlt = {by_q[W-1], by_q} - {ay_q[W-1], ay_q};
      ofs = {tx[W-1], tx} - {ax_q[W-1], ax_q};
      den = {bx_q[W-1], bx_q} - {ax_q[W-1], ax_q};
    end
    // One restoring division step
    rem_sh = {rem_q[W:0], num_q[NB-1]};
    // Signed quotient and new coordinate
    qs     = neg_q ? -$signed(num_q[W:0]) : $signed(num_q[W:0]);
    newc_w = {base_q[W-1], base_q} + qs;
    newc   = newc_w[W-1:0];
    nx     = ybound_q ? newc : tgt_q;
    ny     = ybound_q ? tgt_q : newc;
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || pop_i);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    ca_d = ca_q; cb_d = cb_q;
    pass_d     = pass_q;
    acc_d      = acc_q;
    move_a_d   = move_a_q;
    ybound_d   = ybound_q;
    base_d     = base_q;
    tgt_d      = tgt_q;
    dlt_mag_d  = dlt_mag_q;
    dist_mag_d = dist_mag_q;
    den_mag_d  = den_mag_q;
    neg_d      = neg_q;
    num_d      = num_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    q_pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          {ax_d, ay_d, bx_d, by_d, ca_d, cb_d} = q_word_i;
          pass_d  = '0;
          q_pop_o = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((ca_q | cb_q) == '0) begin
          acc_d   = 1'b1;
          state_d = ST_DONE;
        end else if (((ca_q & cb_q) != '0) || (pass_q >= 3'(MAX_PASSES)) ||
                     (den == '0)) begin
          acc_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          move_a_d   = (ca_q != '0);
          ybound_d   = ybnd;
          base_d     = ybnd ? ax_q : ay_q;
          tgt_d      = ybnd ? ty : tx;
          dlt_mag_d  = mag(dlt);
          dist_mag_d = mag(ofs);
          den_mag_d  = mag(den);
          neg_d      = dlt[W] ^ ofs[W] ^ den[W];
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        num_d   = NB'(dlt_mag_q * dist_mag_q);
        rem_d   = '0;
        cnt_d   = CNW'(NB);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, den_mag_q}) begin
          rem_d = rem_sh - {1'b0, den_mag_q};
          num_d = {num_q[NB-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          num_d = {num_q[NB-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (move_a_q) begin
          ax_d = nx; ay_d = ny;
          ca_d = region(wide_t'(nx), wide_t'(ny),
                        wide_t'(win_right_i), wide_t'(win_bottom_i));
        end else begin
          bx_d = nx; by_d = ny;
          cb_d = region(wide_t'(nx), wide_t'(ny),
                        wide_t'(win_right_i), wide_t'(win_bottom_i));
        end
        pass_d  = pass_q + 1'b1;
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result word holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    ca_q <= ca_d; cb_q <= cb_d;
    acc_q      <= acc_d;
    move_a_q   <= move_a_d;
    ybound_q   <= ybound_d;
    base_q     <= base_d;
    tgt_q      <= tgt_d;
    dlt_mag_q  <= dlt_mag_d;
    dist_mag_q <= dist_mag_d;
    den_mag_q  <= den_mag_d;
    neg_q      <= neg_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    if (out_load) begin
      vis_q <= acc_q;
      osx_q <= acc_q ? ax_q : '0;
      osy_q <= acc_q ? ay_q : '0;
      oex_q <= acc_q ? bx_q : '0;
      oey_q <= acc_q ? by_q : '0;
    end
  end

  assign empty_o           = ~out_valid_q;
  assign visible_o         = vis_q;
  assign clipped_start_x_o = osx_q;
  assign clipped_start_y_o = osy_q;
  assign clipped_end_x_o   = oex_q;
  assign clipped_end_y_o   = oey_q;

  // Pass count never runs beyond the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) pass_q <= 3'(MAX_PASSES))
    else $error("clip pass count overran");

  // Divider counter stays within its step count while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0) && (cnt_q <= CNW'(NB)))
    else $error("divider step count out of range");

  // A rejected word carries zero endpoints
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !vis_q) |-> (osx_q == '0) && (osy_q == '0) &&
                                (oex_q == '0) && (oey_q == '0))
    else $error("rejected segment with nonzero endpoints");

  // A waiting result is not dropped without a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> out_valid_q)
    else $error("result word lost");

endmodule

// ===== rtl/line_segment_clipper_core.sv =====
// Top level of the Cohen-Sutherland line segment clipper: window registers,
// front end, queue and back end. Depends on lsc_pkg, lsc_front, lsc_queue, lsc_back.
//
// Usage:
//   Input side is a queue: present a segment on start_x_i..end_y_i and raise
//   push; the word is taken on a clock edge with push high and full low.
//   Result side is a queue too: while empty is low the oldest result sits on
//   visible_o and clipped_*_o; it is taken on an edge with pop high.
//   Window limits are written through wr_en_i / wr_idx_i / wr_data_i (index 0
//   right limit, 1 bottom limit) while the block is idle; reset gives 127, 63.
//   A two-word queue sits between the classifier and the clipping engine, so
//   segments keep being accepted while the engine works.
//   A segment takes 0 to 4 clip passes between queue head and result register.
//   Each pass is one setup, one multiply, 2*COORD_BITS+2 bit-serial divide
//   steps and one update; the serial divider sets the throughput, one segment
//   at a time. Reset empties the queue and the result register. If the
//   receiver stalls, the finished result is held, the engine waits, and full
//   rises when the queue fills.
module line_segment_clipper_core #(
  parameter int unsigned COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         visible_o,
  output logic signed [COORD_BITS-1:0] clipped_start_x_o,
  output logic signed [COORD_BITS-1:0] clipped_start_y_o,
  output logic signed [COORD_BITS-1:0] clipped_end_x_o,
  output logic signed [COORD_BITS-1:0] clipped_end_y_o,
  input  logic                         wr_en_i,
  input  logic                         wr_idx_i,
  input  logic        [COORD_BITS-2:0] wr_data_i
);
  import lsc_pkg::*;

  localparam int unsigned QW = 4 * COORD_BITS + 8;

  logic [COORD_BITS-2:0] win_right_q, win_bottom_q;
  logic                  q_full, q_push, q_valid, q_pop;
  logic [QW-1:0]         q_in, q_out;

  // Window limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_right_q  <= (COORD_BITS-1)'(127);
      win_bottom_q <= (COORD_BITS-1)'(63);
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_WINDOW_RIGHT:  win_right_q  <= wr_data_i;
        CFG_WINDOW_BOTTOM: win_bottom_q <= wr_data_i;
        default: ;
      endcase
    end
  end

  lsc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .push_i       (push),
    .full_o       (full),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .win_right_i  (win_right_q),
    .win_bottom_i (win_bottom_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_word_o     (q_in)
  );

  lsc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .word_o  (q_out)
  );

  lsc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .win_right_i       (win_right_q),
    .win_bottom_i      (win_bottom_q),
    .q_valid_i         (q_valid),
    .q_word_i          (q_out),
    .q_pop_o           (q_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .visible_o         (visible_o),
    .clipped_start_x_o (clipped_start_x_o),
    .clipped_start_y_o (clipped_start_y_o),
    .clipped_end_x_o   (clipped_end_x_o),
    .clipped_end_y_o   (clipped_end_y_o)
  );

endmodule

// ===== verif/line_segment_clipper_checker.sv =====
// Checker for the line segment clipper: watches the segment and result
// channels, predicts each clipped result and compares. Depends on lsc_pkg.
module line_segment_clipper_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  input  logic                         full,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         empty,
  input  logic                         pop,
  input  logic                         visible_o,
  input  logic signed [COORD_BITS-1:0] clipped_start_x_o,
  input  logic signed [COORD_BITS-1:0] clipped_start_y_o,
  input  logic signed [COORD_BITS-1:0] clipped_end_x_o,
  input  logic signed [COORD_BITS-1:0] clipped_end_y_o,
  input  logic                         wr_en_i,
  input  logic                         wr_idx_i,
  input  logic        [COORD_BITS-2:0] wr_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    logic   vis;
    coord_t sx, sy, ex, ey;
  } clip_word_t;

  clip_word_t clip_q[$];
  longint     win_right = 127;
  longint     win_bottom = 63;
  int         fails = 0;

  function automatic outcode_t zone(longint x, longint y);
    outcode_t c;
    c = '0;
    if (x < 0) c |= CODE_LEFT;
    else if (x > win_right) c |= CODE_RIGHT;
    if (y < 0) c |= CODE_BOTTOM;
    else if (y > win_bottom) c |= CODE_TOP;
    return c;
  endfunction

  // Cohen-Sutherland with at most four passes; quotients truncate toward zero
  function automatic clip_word_t clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint ax, ay, bx, by, nx, ny, den, lim;
    outcode_t ca, cb, co;
    int passes;
    clip_word_t w;
    ax = sx; ay = sy; bx = ex; by = ey;
    ca = zone(ax, ay);
    cb = zone(bx, by);
    passes = 0;
    w = '0;
    forever begin
      if ((ca | cb) == 0) begin
        w.vis = 1'b1;
        w.sx = coord_t'(ax); w.sy = coord_t'(ay);
        w.ex = coord_t'(bx); w.ey = coord_t'(by);
        break;
      end
      if ((ca & cb) != 0 || passes >= MAX_PASSES) break;
      co = (ca != 0) ? ca : cb;
      if ((co & (CODE_TOP | CODE_BOTTOM)) != 0) begin
        lim = (co & CODE_TOP) ? win_bottom : 0;
        den = by - ay;
        if (den == 0) break;
        nx = ax + ((bx - ax) * (lim - ay)) / den;
        ny = lim;
      end else begin
        lim = (co & CODE_RIGHT) ? win_right : 0;
        den = bx - ax;
        if (den == 0) break;
        ny = ay + ((by - ay) * (lim - ax)) / den;
        nx = lim;
      end
      if (ca != 0) begin
        ax = nx; ay = ny; ca = zone(ax, ay);
      end else begin
        bx = nx; by = ny; cb = zone(bx, by);
      end
      passes++;
    end
    return w;
  endfunction

  assign pending_o    = clip_q.size();
  assign fail_count_o = fails;

  // Track window writes, predict on every accepted segment, check every result
  always @(posedge clk_i) begin
    clip_word_t exp_w, got;
    if (rst_ni) begin
      if (wr_en_i) begin
        if (wr_idx_i == CFG_WINDOW_RIGHT) win_right = wr_data_i;
        else win_bottom = wr_data_i;
      end
      if (pop && !empty) begin
        got = {visible_o, clipped_start_x_o, clipped_start_y_o,
               clipped_end_x_o, clipped_end_y_o};
        if (clip_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_w = clip_q.pop_front();
          if (got !== exp_w) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp vis=%0d %0d,%0d %0d,%0d  got vis=%0d %0d,%0d %0d,%0d",
                       exp_w.vis, exp_w.sx, exp_w.sy, exp_w.ex, exp_w.ey,
                       got.vis, got.sx, got.sy, got.ex, got.ey);
          end
        end
      end
      if (push && !full)
        clip_q.push_back(clip_segment(start_x_i, start_y_i, end_x_i, end_y_i));
    end
  end

endmodule

// ===== verif/line_segment_clipper_core_test.sv =====
// Testbench top for the line segment clipper: makes segments, window writes
// and receiver stalls, and gives the verdict. Depends on lsc_pkg and the checker.
module line_segment_clipper_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  localparam int CW = 12;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0, pop = 1'b0, full, empty;
  logic signed [CW-1:0] sx = '0, sy = '0, ex = '0, ey = '0;
  logic visible_o;
  logic signed [CW-1:0] csx, csy, cex, cey;
  logic wr_en_i = 1'b0, wr_idx_i = 1'b0;
  logic [CW-2:0] wr_data_i = '0;
  int fail_count, pending, idle_cycles;
  bit quiet_sink = 1'b0;

  always #5 clk_i = ~clk_i;

  line_segment_clipper_core #(.COORD_BITS(CW)) DUT (
    .clk_i, .rst_ni, .push, .full,
    .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .empty, .pop, .visible_o,
    .clipped_start_x_o(csx), .clipped_start_y_o(csy),
    .clipped_end_x_o(cex), .clipped_end_y_o(cey),
    .wr_en_i, .wr_idx_i, .wr_data_i);

  line_segment_clipper_checker #(.COORD_BITS(CW)) u_checker (
    .clk_i, .rst_ni, .push, .full,
    .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .empty, .pop, .visible_o,
    .clipped_start_x_o(csx), .clipped_start_y_o(csy),
    .clipped_end_x_o(cex), .clipped_end_y_o(cey),
    .wr_en_i, .wr_idx_i, .wr_data_i,
    .fail_count_o(fail_count), .pending_o(pending));

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, none in quiet phase
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet_sink && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        pop <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else pop <= 1'b1;
    end
  end

  // One register write, then the write enable goes low again before the task returns
  task automatic write_window(input logic idx, input int val);
    wr_en_i <= 1'b1; wr_idx_i <= idx; wr_data_i <= val[CW-2:0];
    @(posedge clk_i);
    wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every result is back, then let a finished engine settle
  task automatic drain_block();
    while (pending != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  // Present one segment; hold push until taken, optionally idle afterwards
  task automatic send_segment(input int ax, input int ay, input int bx, input int by,
                              input bit gaps);
    int n;
    push <= 1'b1;
    sx <= ax[CW-1:0]; sy <= ay[CW-1:0]; ex <= bx[CW-1:0]; ey <= by[CW-1:0];
    do @(posedge clk_i); while (full);
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int pick_coord(int lim);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4095) - 2048;
      1: return -2048;
      2: return 2047;
      default: return int'($urandom_range(0, lim + 40)) - 20;
    endcase
  endfunction

  initial begin
    int r, b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: inside, trivial reject, every edge, corners, extremes, vertical
    send_segment(10, 10, 100, 50, 1'b0);
    send_segment(-5, -5, -10, 40, 1'b0);
    send_segment(-50, 30, 200, 30, 1'b0);
    send_segment(60, -40, 60, 100, 1'b0);
    send_segment(-2048, -2048, 2047, 2047, 1'b0);
    send_segment(2047, -2048, -2048, 2047, 1'b0);
    send_segment(0, 0, 127, 63, 1'b0);
    send_segment(128, 0, 128, 63, 1'b0);
    send_segment(-10, 70, 140, -5, 1'b0);
    send_segment(-1, 65, 5, 70, 1'b0);
    send_segment(-2048, 2047, -2048, 2047, 1'b0);
    send_segment(200, 10, 10, 200, 1'b1);
    send_segment(-1000, 20, 1000, 25, 1'b1);
    push <= 1'b0;
    drain_block();
    write_window(CFG_WINDOW_RIGHT, 0);
    write_window(CFG_WINDOW_BOTTOM, 2047);
    send_segment(-5, 5, 5, 3000, 1'b0);
    send_segment(0, -2048, 0, 2047, 1'b0);
    send_segment(-2048, -1, 2047, 1, 1'b0);
    push <= 1'b0;
    drain_block();
    write_window(CFG_WINDOW_RIGHT, 2047);
    write_window(CFG_WINDOW_BOTTOM, 0);
    send_segment(-2048, 1, 2047, -1, 1'b0);
    send_segment(-2048, -2048, 2047, 2047, 1'b0);
    push <= 1'b0;
    drain_block();
    // Random phases under several window settings
    for (int phase = 0; phase < 8; phase++) begin
      r = (phase == 0) ? 2047 : (phase == 1) ? 0 : $urandom_range(0, 2047);
      b = (phase == 2) ? 2047 : (phase == 3) ? 0 : $urandom_range(0, 2047);
      if (phase >= 4 && $urandom_range(0, 1)) r = $urandom_range(0, 200);
      write_window(CFG_WINDOW_RIGHT, r);
      write_window(CFG_WINDOW_BOTTOM, b);
      if (phase == 7) quiet_sink = 1'b1;
      for (int i = 0; i < 230; i++)
        send_segment(pick_coord(r), pick_coord(b), pick_coord(r), pick_coord(b),
                     phase != 7);
      push <= 1'b0;
      drain_block();
    end
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
